FILE: src/gle_pkg.sv
// Shared types and constants of the GIF LZW encoder.
package gle_pkg;

    localparam int EPOCH_W = 8;
    localparam logic [3:0] SIZE_MIN = 4'd2;
    localparam logic [3:0] SIZE_MAX = 4'd8;
    localparam logic [3:0] SIZE_RESET = 4'd8;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_READ  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_NEXT  = 5'b10000
    } t_state;

    // What the sequencer does once the packer has no whole byte left.
    typedef enum logic [1:0] {
        A_GROW      = 2'd0,
        A_END_CHECK = 2'd1,
        A_EOI       = 2'd2,
        A_FLUSH     = 2'd3
    } t_after;

    function automatic logic [3:0] clamp_size(input logic [3:0] m);
        logic [3:0] r;
        r = m;
        if (m < SIZE_MIN) r = SIZE_MIN;
        if (m > SIZE_MAX) r = SIZE_MAX;
        return r;
    endfunction

endpackage

FILE: src/gle_dict_ram.sv
// Single-port-write, single-port-read dictionary RAM with registered read data.
module gle_dict_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

FILE: src/gif_lzw_encoder.sv
// Top level of the GIF variable-width LZW encoder.
//
// Channel   Direction  tdata               tuser  tlast
// s_axis    in         pixel_index [7:0]   -      last_pixel
// m_axis    out        out_byte [7:0]      -      last_byte
// cfg       in         min_code_size [3:0] (write enable, no handshake)
//
// A pixel whose key hits at the home slot passes through accept (which issues
// the dictionary read), compare and the end-of-frame check; each extra
// collision costs one more read, set by the single read port of the
// dictionary RAM. A miss adds its emitted bytes and the width check; a table
// restart adds the clear code's bytes. Frame end adds prefix, EOI and flush bytes.
// A stalled output holds the byte packer and thus the pixel input.
// After reset, and after every 255 table restarts, a clearing pass over all
// HASH_SLOTS slots runs before the next pixel is accepted.
module gif_lzw_encoder #(
    parameter int MAX_CODE_BITS = 12,
    // Number of hash slots; a power of two, so the hash is the low key bits.
    parameter int HASH_SLOTS = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,      // min_code_size
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] pixel_index
    input  logic       i_s_axis_tlast,   // last_pixel
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast    // last_byte
);
    import gle_pkg::*;

    localparam int CW    = MAX_CODE_BITS;
    localparam int NCW   = CW + 1;
    localparam int KEY_W = CW + 8;
    localparam int HW    = $clog2(HASH_SLOTS);
    localparam int ACC_W = CW + 8;
    localparam int DW    = EPOCH_W + KEY_W + CW;

    // Registers.
    t_state             r_state;
    t_after             r_after;
    logic [3:0]         r_min_size;
    logic [3:0]         r_size;
    logic [3:0]         r_width;
    logic [NCW-1:0]     r_next;
    logic [CW-1:0]      r_prefix;
    logic [7:0]         r_k;
    logic               r_last;
    logic               r_final;
    logic               r_open;
    logic [ACC_W-1:0]   r_acc;
    logic [4:0]         r_cnt;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_sweep_pend;
    logic [HW-1:0]      r_sweep_addr;
    logic [KEY_W-1:0]   r_key;
    logic [HW-1:0]      r_addr;
    logic               r_ovalid;
    logic [7:0]         r_odata;
    logic               r_olast;

    // Dictionary RAM ports.
    logic          m_we;
    logic [HW-1:0] m_waddr;
    logic [DW-1:0] m_wdata;
    logic          m_re;
    logic [HW-1:0] m_raddr;
    logic [DW-1:0] m_rdata;

    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic [3:0]         w_size_sel;
    logic [3:0]         w_new_size;
    logic [7:0]         w_in_k;
    logic [KEY_W-1:0]   w_in_key;
    logic [EPOCH_W-1:0] w_rd_epoch;
    logic [KEY_W-1:0]   w_rd_key;
    logic [CW-1:0]      w_rd_code;
    logic               w_used;
    logic               w_match;
    logic [CW-1:0]      w_clear_code;
    logic [CW-1:0]      w_eoi_code;

    // Adds one code, masked to the current width, above the pending bits.
    function automatic logic [ACC_W-1:0] f_put(input logic [ACC_W-1:0] acc,
                                               input logic [4:0] cnt,
                                               input logic [CW-1:0] code,
                                               input logic [3:0] width);
        logic [CW-1:0] m;
        m = code & ~({CW{1'b1}} << width);
        return acc | (ACC_W'(m) << cnt);
    endfunction

    assign w_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free   = !r_ovalid || i_m_axis_tready;
    // The output register takes a new byte this cycle.
    assign w_out_load   = w_out_free &&
                          (((r_state == S_DRAIN) && (r_cnt >= 5'd8)) ||
                           ((r_state == S_NEXT) && (r_after == A_FLUSH) &&
                            (r_cnt != 5'd0)));
    assign w_new_size   = clamp_size(r_min_size);
    assign w_size_sel   = r_open ? r_size : w_new_size;
    assign w_in_k       = i_s_axis_tdata & ~(8'hFF << w_size_sel);
    assign w_in_key     = {r_prefix, w_in_k};
    assign w_rd_epoch   = m_rdata[DW-1 -: EPOCH_W];
    assign w_rd_key     = m_rdata[CW +: KEY_W];
    assign w_rd_code    = m_rdata[CW-1:0];
    // A slot counts as used only when it carries the current epoch mark.
    assign w_used       = (w_rd_epoch == r_epoch);
    assign w_match      = w_used && (w_rd_key == r_key);
    assign w_clear_code = CW'(1) << r_size;
    assign w_eoi_code   = w_clear_code + CW'(1);

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_sweep_pend;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_addr;
        m_wdata = {r_epoch, r_key, r_next[CW-1:0]};
        m_re    = 1'b0;
        m_raddr = w_in_key[HW-1:0];
        case (r_state)
            S_SWEEP: begin
                m_we    = 1'b1;
                m_waddr = r_sweep_addr;
                m_wdata = '0;
            end
            S_IDLE: begin
                m_re = w_accept && r_open;
            end
            S_READ: begin
                if (!w_used) begin
                    m_we = 1'b1;
                end else if (!w_match) begin
                    m_re    = 1'b1;
                    m_raddr = r_addr + HW'(1);
                end
            end
            default: begin
                m_we = 1'b0;
            end
        endcase
    end

    gle_dict_ram #(
        .ADDR_W(HW),
        .DATA_W(DW)
    ) u_dict (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_re   (m_re),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after      <= A_END_CHECK;
            r_min_size   <= SIZE_RESET;
            r_size       <= SIZE_RESET;
            r_width      <= SIZE_RESET + 4'd1;
            r_next       <= (NCW'(1) << SIZE_RESET) + NCW'(2);
            r_prefix     <= '0;
            r_last       <= 1'b0;
            r_final      <= 1'b0;
            r_open       <= 1'b0;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_epoch      <= EPOCH_W'(1);
            r_sweep_pend <= 1'b1;
            r_sweep_addr <= '0;
            r_ovalid     <= 1'b0;
            r_olast      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_size <= i_cfg_wdata;
            end
            if (i_m_axis_tready && !w_out_load) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (r_sweep_pend) begin
                        r_state      <= S_SWEEP;
                        r_sweep_addr <= '0;
                    end else if (w_accept) begin
                        r_last <= i_s_axis_tlast;
                        r_k    <= w_in_k;
                        if (!r_open) begin
                            // Frame start: restart the table and send a clear code.
                            r_size   <= w_new_size;
                            r_width  <= w_new_size + 4'd1;
                            r_next   <= (NCW'(1) << w_new_size) + NCW'(2);
                            r_acc    <= f_put('0, 5'd0, CW'(1) << w_new_size,
                                              w_new_size + 4'd1);
                            r_cnt    <= 5'(w_new_size) + 5'd1;
                            r_prefix <= CW'(w_in_k);
                            r_open   <= 1'b1;
                            r_after  <= A_END_CHECK;
                            r_state  <= S_DRAIN;
                            if (r_epoch == {EPOCH_W{1'b1}}) begin
                                r_epoch      <= EPOCH_W'(1);
                                r_sweep_pend <= 1'b1;
                            end else begin
                                r_epoch <= r_epoch + EPOCH_W'(1);
                            end
                        end else begin
                            r_key   <= w_in_key;
                            r_addr  <= w_in_key[HW-1:0];
                            r_state <= S_READ;
                        end
                    end
                end
                S_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + HW'(1);
                    if (r_sweep_addr == {HW{1'b1}}) begin
                        r_sweep_pend <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (!w_used) begin
                        // Miss: the entry is written by the RAM port this cycle.
                        r_acc    <= f_put(r_acc, r_cnt, r_prefix, r_width);
                        r_cnt    <= r_cnt + 5'(r_width);
                        r_next   <= r_next + NCW'(1);
                        r_prefix <= CW'(r_k);
                        r_after  <= A_GROW;
                        r_state  <= S_DRAIN;
                    end else if (w_match) begin
                        r_prefix <= w_rd_code;
                        r_after  <= A_END_CHECK;
                        r_state  <= S_NEXT;
                    end else begin
                        r_addr <= r_addr + HW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_cnt >= 5'd8) begin
                        if (w_out_free) begin
                            r_ovalid <= 1'b1;
                            r_odata  <= r_acc[7:0];
                            r_olast  <= r_final && (r_cnt == 5'd8);
                            r_acc    <= r_acc >> 8;
                            r_cnt    <= r_cnt - 5'd8;
                        end
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    case (r_after)
                        A_GROW: begin
                            r_after <= A_END_CHECK;
                            if (r_next > (NCW'(1) << r_width)) begin
                                if (r_width < 4'(MAX_CODE_BITS)) begin
                                    r_width <= r_width + 4'd1;
                                end else begin
                                    // Table full: clear code at full width, then restart.
                                    r_acc   <= f_put(r_acc, r_cnt, w_clear_code, r_width);
                                    r_cnt   <= r_cnt + 5'(r_width);
                                    r_width <= r_size + 4'd1;
                                    r_next  <= (NCW'(1) << r_size) + NCW'(2);
                                    r_state <= S_DRAIN;
                                    if (r_epoch == {EPOCH_W{1'b1}}) begin
                                        r_epoch      <= EPOCH_W'(1);
                                        r_sweep_pend <= 1'b1;
                                    end else begin
                                        r_epoch <= r_epoch + EPOCH_W'(1);
                                    end
                                end
                            end
                        end
                        A_END_CHECK: begin
                            if (r_last) begin
                                r_acc   <= f_put(r_acc, r_cnt, r_prefix, r_width);
                                r_cnt   <= r_cnt + 5'(r_width);
                                r_after <= A_EOI;
                                r_state <= S_DRAIN;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        A_EOI: begin
                            r_acc   <= f_put(r_acc, r_cnt, w_eoi_code, r_width);
                            r_cnt   <= r_cnt + 5'(r_width);
                            r_final <= 1'b1;
                            r_after <= A_FLUSH;
                            r_state <= S_DRAIN;
                        end
                        A_FLUSH: begin
                            if (r_cnt == 5'd0) begin
                                r_open  <= 1'b0;
                                r_final <= 1'b0;
                                r_state <= S_IDLE;
                            end else if (w_out_free) begin
                                r_ovalid <= 1'b1;
                                r_odata  <= r_acc[7:0];
                                r_olast  <= 1'b1;
                                r_acc    <= '0;
                                r_cnt    <= '0;
                                r_open   <= 1'b0;
                                r_final  <= 1'b0;
                                r_state  <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: dv/gle_checker.sv
// Scoreboard for the GIF LZW encoder: predicts the packed code stream and compares it.
`timescale 1ns / 1ps

module gle_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic       i_m_tlast,
    output int         o_errors,
    output int         o_pending,
    output int         o_bytes_seen
);
    import gle_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_code_byte;

    t_code_byte  byte_q[$];
    t_code_byte  step_q[$];

    // Model state of the encoder.
    logic [3:0]  size_reg;
    logic [3:0]  frame_size;
    logic [11:0] prefix;
    int          next_code;
    int          width;
    logic [7:0]  pack_buf;
    int          pack_bits;
    logic        frame_open;
    int          dict[int];

    assign o_pending = byte_q.size();

    task automatic put_code(input int code);
        int acc;
        int bits;
        acc  = int'(pack_buf) | ((code & ((1 << width) - 1)) << pack_bits);
        bits = pack_bits + width;
        while (bits >= 8) begin
            step_q.insert(step_q.size(), '{data: acc[7:0], last: 1'b0});
            acc  = acc >> 8;
            bits = bits - 8;
        end
        pack_buf  = acc[7:0];
        pack_bits = bits;
    endtask

    task automatic restart_table();
        dict.delete();
        next_code = (1 << frame_size) + 2;
        width     = frame_size + 1;
    endtask

    // Works out the bytes that one accepted pixel produces.
    task automatic encode_pixel(input logic [7:0] pix, input logic last);
        int         sym;
        int         key;
        t_code_byte tail;
        step_q.delete();
        if (!frame_open) begin
            frame_size = size_reg;
            if (size_reg < SIZE_MIN) frame_size = SIZE_MIN;
            if (size_reg > SIZE_MAX) frame_size = SIZE_MAX;
            pack_buf  = '0;
            pack_bits = 0;
            restart_table();
            put_code(1 << frame_size);
            prefix     = 12'(pix & ((1 << frame_size) - 1));
            frame_open = 1'b1;
        end else begin
            sym = pix & ((1 << frame_size) - 1);
            key = (int'(prefix) << 8) | sym;
            if (dict.exists(key)) begin
                prefix = 12'(dict[key]);
            end else begin
                put_code(int'(prefix));
                dict[key] = next_code;
                next_code++;
                if (next_code > (1 << width)) begin
                    if (width < 12) begin
                        width++;
                    end else begin
                        // Table is full at the widest code: clear and start over.
                        put_code(1 << frame_size);
                        restart_table();
                    end
                end
                prefix = 12'(sym);
            end
        end
        if (last) begin
            put_code(int'(prefix));
            put_code((1 << frame_size) + 1);
            if (pack_bits > 0) begin
                step_q.insert(step_q.size(), '{data: pack_buf, last: 1'b0});
                pack_buf  = '0;
                pack_bits = 0;
            end
            if (step_q.size() > 0) begin
                tail = step_q.pop_back();
                tail.last = 1'b1;
                step_q.insert(step_q.size(), tail);
            end
            frame_open = 1'b0;
        end
        foreach (step_q[i]) byte_q.insert(byte_q.size(), step_q[i]);
    endtask

    always @(posedge i_clk) begin
        t_code_byte want;
        if (!i_rst_n) begin
            size_reg     = SIZE_RESET;
            frame_size   = SIZE_RESET;
            frame_open   = 1'b0;
            prefix       = '0;
            pack_buf     = '0;
            pack_bits    = 0;
            o_errors     = 0;
            o_bytes_seen = 0;
            restart_table();
            byte_q.delete();
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) encode_pixel(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                o_bytes_seen++;
                if (byte_q.size() == 0) begin
                    $error("out_byte: unexpected transaction, data %02h last %0b",
                           i_m_tdata, i_m_tlast);
                    o_errors++;
                end else begin
                    want = byte_q.pop_front();
                    if (want.data !== i_m_tdata) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, i_m_tdata);
                        o_errors++;
                    end
                    if (want.last !== i_m_tlast) begin
                        $error("last_byte: expected %0b, actual %0b", want.last, i_m_tlast);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the GIF LZW encoder: stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT  = 30000;  // covers the table clearing pass after reset
    localparam int SETTLE_WAIT = 40;     // pixels that hit the table produce no byte
    localparam int LONG_HOLD   = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int errors;
    int pending;
    int bytes_seen;
    int pixels_sent;
    int frames_sent;
    int idle_cycles = 0;
    bit gaps_on;
    bit hold_req;

    gif_lzw_encoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast)
    );

    gle_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_bytes_seen(bytes_seen)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: any long stretch with no transaction on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: a random stall before each byte, plus one long hold-off on request.
    initial begin
        int gap;
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                held = 1'b1;
            end
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            // Tvalid read just after the falling edge holds for the next rising edge.
            #1;
            while (!m_tvalid) begin
                @(negedge i_clk);
                #1;
            end
        end
    end

    // Offers one pixel after a random gap and returns after the transaction.
    task automatic send_pixel(input logic [7:0] pix, input logic last);
        int gap;
        bit took;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pix;
        s_tlast  = last;
        took     = 1'b0;
        while (!took) begin
            #1;
            took = s_tready;
            @(negedge i_clk);
        end
        pixels_sent++;
        if (last) frames_sent++;
    endtask

    // A frame of n pixels; a small alphabet gives long dictionary hits.
    task automatic send_frame(input int n, input int alphabet);
        logic [7:0] pix;
        for (int i = 0; i < n; i++) begin
            pix = (alphabet >= 256) ? 8'($urandom) : 8'($urandom_range(0, alphabet - 1));
            // Upper bits should be masked off, so scatter garbage into them now and then.
            if ($urandom_range(0, 3) == 0) pix = pix ^ (8'($urandom) & 8'hF0);
            send_pixel(pix, i == n - 1);
        end
    endtask

    // Register writes happen only once the encoder has drained.
    task automatic write_size(input logic [3:0] value);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_WAIT) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        int len;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        pixels_sent = 0;
        frames_sent = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single-pixel frames at the reset size, repeats, then size extremes.
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b1);
        write_size(4'd2);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'h03, 1'b1);
        write_size(4'd0);            // below the range, acts as the smallest size
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h01, 1'b1);
        write_size(4'd15);           // above the range, acts as the largest size
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b1);
        write_size(4'd1);
        send_pixel(8'hFE, 1'b1);
        write_size(4'd9);
        send_pixel(8'h12, 1'b0);
        send_pixel(8'h12, 1'b1);
        write_size(4'd8);
        // Written while a frame is open: only the next frame picks this up.
        send_pixel(8'h44, 1'b0);
        write_size(4'd3);
        send_pixel(8'hC4, 1'b1);

        // Random frames, a fresh size before most of them.
        while (pixels_sent < 140) begin
            if ($urandom_range(0, 3) != 0) write_size(4'($urandom));
            if (frames_sent == 12) hold_req = 1'b1;   // receiver backs up the pipe
            gaps_on = !(frames_sent >= 18 && frames_sent < 22);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0: send_frame(len, 2);
                1: send_frame(len, 4);
                default: send_frame(len, 256);
            endcase
        end

        // Pause until everything is out, then close with one small-alphabet frame.
        s_tvalid = 1'b0;
        wait (pending == 0);
        gaps_on = 1'b1;
        write_size(4'd2);
        send_frame(20, 4);

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_WAIT) @(negedge i_clk);
        $display("Sent %0d pixels in %0d frames over several code sizes.",
                 pixels_sent, frames_sent);
        $display("Checked %0d code stream bytes under random and long output stalls.",
                 bytes_seen);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: gif_lzw_encoder.f
src/gle_pkg.sv
src/gle_dict_ram.sv
src/gif_lzw_encoder.sv
dv/gle_checker.sv
dv/tb_top.sv
